// ===== sv/sbi_pkg.sv =====
package sbi_pkg;

    // Table geometry
    localparam int MAX_BREAKPOINTS = 16;
    localparam int ADDR_W          = $clog2(MAX_BREAKPOINTS);
    localparam int CNT_W           = $clog2(MAX_BREAKPOINTS + 1);
    localparam int DATA_W          = 16;
    localparam int ENTRY_W         = 2 * DATA_W;

    // Serial divider: one quotient bit per step
    localparam int DIV_STEPS = DATA_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_REFUSED  = 2'd1;
    localparam logic [1:0] ST_ANSWERED = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_STEP,
        S_Q_FIRST,
        S_Q_LAST,
        S_Q_SCAN,
        S_MUL,
        S_DIV_INIT,
        S_DIV
    } t_state;

    // Table read address source
    typedef enum logic [1:0] {
        RD_CNT_M1,
        RD_IDX_M2,
        RD_ZERO,
        RD_IDX_P1
    } t_rd_sel;

    // Walk index update
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LOAD_CNT,
        IDX_CLEAR,
        IDX_DEC,
        IDX_INC
    } t_idx_op;

    // Table write data source
    typedef enum logic {
        WR_SHIFT,
        WR_NEW
    } t_wr_sel;

    // Result value source
    typedef enum logic [1:0] {
        RES_ZERO,
        RES_RD_Y,
        RES_INTERP
    } t_res_sel;

    typedef struct packed {
        logic       load_item;
        logic       rd_en;
        t_rd_sel    rd_sel;
        t_idx_op    idx_op;
        logic       wr_en;
        t_wr_sel    wr_sel;
        logic       cnt_inc;
        logic       prev_load;
        logic       diff_load;
        logic       mul_load;
        logic       div_start;
        logic       div_step;
        logic       res_load;
        t_res_sel   res_sel;
        logic [1:0] res_status;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic idx_zero;
        logic ins_shift;   // read entry x above the new x
        logic scan_hit;    // read entry x at or above the query
        logic last_hit;    // query at or above the read entry x
        logic div_done;
    } t_dp_stat;

endpackage

// ===== sv/sorted_breakpoint_interpolator_core.sv =====
// Insert: larger entries are shifted up (0 to 15 of them), then the new pair is written and strobed.
// Refused insert or query on an empty table: strobe in the cycle after accept.
// Query at or below the first x is answered from S_Q_FIRST; at or above the last x, from S_Q_LAST.
// Interpolated query: walk to the upper neighbor, then a multiply and a 16-step divide.
// A new transaction is taken in the strobe cycle; results cannot be stalled.
// Synchronous active-low reset empties the table; table storage is not cleared.
module sorted_breakpoint_interpolator_core import sbi_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_opcode,
    input  logic signed [DATA_W-1:0] i_x_value,
    input  logic signed [DATA_W-1:0] i_y_value,
    output logic                     o_strobe,
    output logic [1:0]               o_status,
    output logic signed [DATA_W-1:0] o_y_result
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer
    sbi_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .busy     (busy)
    );

    // Table, interpolation arithmetic and result register
    sbi_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_x_value  (i_x_value),
        .i_y_value  (i_y_value),
        .o_stat     (w_stat),
        .o_strobe   (o_strobe),
        .o_status   (o_status),
        .o_y_result (o_y_result)
    );

endmodule

// ===== sv/sbi_ram.sv =====
module sbi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port; read data holds when idle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/sbi_datapath.sv =====
module sbi_datapath import sbi_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic signed [DATA_W-1:0] i_x_value,
    input  logic signed [DATA_W-1:0] i_y_value,
    output t_dp_stat                 o_stat,
    output logic                     o_strobe,
    output logic [1:0]               o_status,
    output logic signed [DATA_W-1:0] o_y_result
);

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          r_idx;
    logic signed [DATA_W-1:0]  r_x_item;
    logic signed [DATA_W-1:0]  r_y_item;
    logic signed [DATA_W-1:0]  r_x0;
    logic signed [DATA_W-1:0]  r_y0;
    logic                      r_neg;
    logic [DATA_W-1:0]         r_dy_mag;
    logic [DATA_W-1:0]         r_dx;
    logic [DATA_W-1:0]         r_den;
    logic [2*DATA_W-1:0]       r_prod;
    logic [DATA_W-1:0]         r_rem;
    logic [DATA_W-1:0]         r_low;
    logic [DATA_W-1:0]         r_quo;
    logic [DIV_CNT_W-1:0]      r_div_cnt;
    logic                      r_strobe;
    logic [1:0]                r_status;
    logic signed [DATA_W-1:0]  r_y_result;

    logic [CNT_W-1:0]          w_rd_idx;
    logic [ENTRY_W-1:0]        w_rd_data;
    logic [ENTRY_W-1:0]        w_wr_data;
    logic signed [DATA_W-1:0]  w_rd_x;
    logic signed [DATA_W-1:0]  w_rd_y;
    logic signed [DATA_W:0]    w_dy;
    logic signed [DATA_W:0]    w_dy_abs;
    logic signed [DATA_W:0]    w_dx;
    logic signed [DATA_W:0]    w_den;
    logic [DATA_W:0]           w_shift;
    logic [DATA_W:0]           w_trial;
    logic signed [DATA_W:0]    w_quo_s;
    logic signed [DATA_W:0]    w_y_sum;
    logic signed [DATA_W-1:0]  w_y_sel;

    // Read address of the breakpoint table
    always_comb begin
        case (i_cmd.rd_sel)
            RD_CNT_M1: w_rd_idx = r_count - CNT_W'(1);
            RD_IDX_M2: w_rd_idx = r_idx - CNT_W'(2);
            RD_ZERO:   w_rd_idx = '0;
            RD_IDX_P1: w_rd_idx = r_idx + CNT_W'(1);
            default:   w_rd_idx = '0;
        endcase
    end

    assign w_wr_data = (i_cmd.wr_sel == WR_NEW) ? {r_x_item, r_y_item} : w_rd_data;

    // Breakpoint table, entry = {x, y}
    sbi_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BREAKPOINTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (r_idx[ADDR_W-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (w_rd_idx[ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_x = w_rd_data[ENTRY_W-1:DATA_W];
    assign w_rd_y = w_rd_data[DATA_W-1:0];

    // Segment differences against the lower neighbor
    assign w_dy     = {w_rd_y[DATA_W-1], w_rd_y} - {r_y0[DATA_W-1], r_y0};
    assign w_dy_abs = w_dy[DATA_W] ? -w_dy : w_dy;
    assign w_dx     = {r_x_item[DATA_W-1], r_x_item} - {r_x0[DATA_W-1], r_x0};
    assign w_den    = {w_rd_x[DATA_W-1], w_rd_x} - {r_x0[DATA_W-1], r_x0};

    // Restoring divider step; remainder always stays below the divisor
    assign w_shift = {r_rem, r_low[DATA_W-1]};
    assign w_trial = w_shift - {1'b0, r_den};

    // Signed quotient added to the lower y
    assign w_quo_s = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign w_y_sum = {r_y0[DATA_W-1], r_y0} + w_quo_s;

    always_comb begin
        case (i_cmd.res_sel)
            RES_ZERO:   w_y_sel = '0;
            RES_RD_Y:   w_y_sel = w_rd_y;
            RES_INTERP: w_y_sel = w_y_sum[DATA_W-1:0];
            default:    w_y_sel = '0;
        endcase
    end

    // Control registers: point count and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CNT_W'(1);
            end
            r_strobe <= i_cmd.res_load;
        end
    end

    // Walk index
    always_ff @(posedge i_clk) begin
        case (i_cmd.idx_op)
            IDX_LOAD_CNT: r_idx <= r_count;
            IDX_CLEAR:    r_idx <= '0;
            IDX_DEC:      r_idx <= r_idx - CNT_W'(1);
            IDX_INC:      r_idx <= r_idx + CNT_W'(1);
            default:      r_idx <= r_idx;
        endcase
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_x_item <= i_x_value;
            r_y_item <= i_y_value;
        end
        if (i_cmd.prev_load) begin
            r_x0 <= w_rd_x;
            r_y0 <= w_rd_y;
        end
        if (i_cmd.diff_load) begin
            r_neg    <= w_dy[DATA_W];
            r_dy_mag <= w_dy_abs[DATA_W-1:0];
            r_dx     <= w_dx[DATA_W-1:0];
            r_den    <= w_den[DATA_W-1:0];
        end
        if (i_cmd.mul_load) begin
            r_prod <= r_dy_mag * r_dx;
        end
        if (i_cmd.div_start) begin
            r_rem     <= r_prod[2*DATA_W-1:DATA_W];
            r_low     <= r_prod[DATA_W-1:0];
            r_quo     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            if (!w_trial[DATA_W]) begin
                r_rem <= w_trial[DATA_W-1:0];
            end else begin
                r_rem <= w_shift[DATA_W-1:0];
            end
            r_quo     <= {r_quo[DATA_W-2:0], ~w_trial[DATA_W]};
            r_low     <= {r_low[DATA_W-2:0], 1'b0};
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
        if (i_cmd.res_load) begin
            r_status   <= i_cmd.res_status;
            r_y_result <= w_y_sel;
        end
    end

    // Status back to the controller
    assign o_stat.cnt_zero  = (r_count == '0);
    assign o_stat.cnt_full  = (r_count == CNT_W'(MAX_BREAKPOINTS));
    assign o_stat.idx_zero  = (r_idx == '0);
    assign o_stat.ins_shift = (w_rd_x > r_x_item);
    assign o_stat.scan_hit  = (w_rd_x >= r_x_item);
    assign o_stat.last_hit  = (r_x_item >= w_rd_x);
    assign o_stat.div_done  = (r_div_cnt == DIV_CNT_W'(DIV_STEPS));

    assign o_strobe   = r_strobe;
    assign o_status   = r_status;
    assign o_y_result = r_y_result;

endmodule

// ===== sv/sbi_ctrl.sv =====
module sbi_ctrl import sbi_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  logic     i_opcode,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     busy
);

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd w_cmd;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state           = r_state;
        w_cmd.load_item   = 1'b0;
        w_cmd.rd_en       = 1'b0;
        w_cmd.rd_sel      = RD_CNT_M1;
        w_cmd.idx_op      = IDX_HOLD;
        w_cmd.wr_en       = 1'b0;
        w_cmd.wr_sel      = WR_SHIFT;
        w_cmd.cnt_inc     = 1'b0;
        w_cmd.prev_load   = 1'b0;
        w_cmd.diff_load   = 1'b0;
        w_cmd.mul_load    = 1'b0;
        w_cmd.div_start   = 1'b0;
        w_cmd.div_step    = 1'b0;
        w_cmd.res_load    = 1'b0;
        w_cmd.res_sel     = RES_ZERO;
        w_cmd.res_status  = ST_ANSWERED;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    w_cmd.load_item = 1'b1;
                    if (i_opcode == OP_INSERT) begin
                        if (i_stat.cnt_full) begin
                            w_cmd.res_load   = 1'b1;
                            w_cmd.res_status = ST_REFUSED;
                        end else begin
                            // read the top entry, start shifting from the count
                            w_cmd.idx_op = IDX_LOAD_CNT;
                            w_cmd.rd_en  = 1'b1;
                            w_cmd.rd_sel = RD_CNT_M1;
                            n_state      = S_INS_STEP;
                        end
                    end else begin
                        if (i_stat.cnt_zero) begin
                            w_cmd.res_load   = 1'b1;
                            w_cmd.res_status = ST_ANSWERED;
                        end else begin
                            w_cmd.rd_en  = 1'b1;
                            w_cmd.rd_sel = RD_ZERO;
                            w_cmd.idx_op = IDX_CLEAR;
                            n_state      = S_Q_FIRST;
                        end
                    end
                end
            end

            // Move one larger entry up per cycle, then drop the new pair in
            S_INS_STEP: begin
                w_cmd.wr_en = 1'b1;
                if (!i_stat.idx_zero && i_stat.ins_shift) begin
                    w_cmd.wr_sel = WR_SHIFT;
                    w_cmd.idx_op = IDX_DEC;
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_sel = RD_IDX_M2;
                end else begin
                    w_cmd.wr_sel     = WR_NEW;
                    w_cmd.cnt_inc    = 1'b1;
                    w_cmd.res_load   = 1'b1;
                    w_cmd.res_status = ST_INSERTED;
                    n_state          = S_IDLE;
                end
            end

            // Clamp at or below the first breakpoint; this wins over the last
            S_Q_FIRST: begin
                if (i_stat.scan_hit) begin
                    w_cmd.res_load   = 1'b1;
                    w_cmd.res_sel    = RES_RD_Y;
                    w_cmd.res_status = ST_ANSWERED;
                    n_state          = S_IDLE;
                end else begin
                    w_cmd.prev_load = 1'b1;
                    w_cmd.rd_en     = 1'b1;
                    w_cmd.rd_sel    = RD_CNT_M1;
                    n_state         = S_Q_LAST;
                end
            end

            // Clamp at or above the last breakpoint
            S_Q_LAST: begin
                if (i_stat.last_hit) begin
                    w_cmd.res_load   = 1'b1;
                    w_cmd.res_sel    = RES_RD_Y;
                    w_cmd.res_status = ST_ANSWERED;
                    n_state          = S_IDLE;
                end else begin
                    // entry 0 already held as the lower neighbor, scan from 1
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_sel = RD_IDX_P1;
                    w_cmd.idx_op = IDX_INC;
                    n_state      = S_Q_SCAN;
                end
            end

            // Walk up to the first entry at or above the query
            S_Q_SCAN: begin
                if (i_stat.scan_hit) begin
                    w_cmd.diff_load = 1'b1;
                    n_state         = S_MUL;
                end else begin
                    w_cmd.prev_load = 1'b1;
                    w_cmd.idx_op    = IDX_INC;
                    w_cmd.rd_en     = 1'b1;
                    w_cmd.rd_sel    = RD_IDX_P1;
                end
            end

            S_MUL: begin
                w_cmd.mul_load = 1'b1;
                n_state        = S_DIV_INIT;
            end

            S_DIV_INIT: begin
                w_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end

            S_DIV: begin
                if (i_stat.div_done) begin
                    w_cmd.res_load   = 1'b1;
                    w_cmd.res_sel    = RES_INTERP;
                    w_cmd.res_status = ST_ANSWERED;
                    n_state          = S_IDLE;
                end else begin
                    w_cmd.div_step = 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd = w_cmd;
    assign busy  = (r_state != S_IDLE);

endmodule

// ===== sv/sbi_checker.sv =====
module sbi_checker import sbi_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     i_opcode,
    input logic signed [DATA_W-1:0] i_x_value,
    input logic signed [DATA_W-1:0] i_y_value,
    input logic                     o_strobe,
    input logic [1:0]               o_status,
    input logic signed [DATA_W-1:0] o_y_result
);

    // An accepted transaction either answers at once or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted transaction neither busy nor answered");

    // No result appears out of an idle block with no transaction
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !start) |=> !o_strobe)
        else $error("result strobe without a transaction");

    // A result follows either an accept or a busy cycle
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(busy) || $past(start)))
        else $error("result strobe without preceding work");

    // Insert results carry zero and a valid insert code
    a_insert_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_ANSWERED) |->
            ((o_status == ST_INSERTED || o_status == ST_REFUSED) && o_y_result == '0))
        else $error("insert result with bad status or nonzero value");

endmodule

bind sorted_breakpoint_interpolator_core sbi_checker u_sbi_checker (.*);

// ===== tb/sorted_breakpoint_interpolator_core_test.sv =====
`timescale 1ns / 100ps

module sorted_breakpoint_interpolator_core_test;
    import sbi_pkg::*;

    typedef struct {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] y;
    } t_answer;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic                     i_opcode;
    logic signed [DATA_W-1:0] i_x_value;
    logic signed [DATA_W-1:0] i_y_value;
    logic                     o_strobe;
    logic [1:0]               o_status;
    logic signed [DATA_W-1:0] o_y_result;

    // Breakpoint table as the testbench expects it
    logic signed [DATA_W-1:0] bp_x [MAX_BREAKPOINTS];
    logic signed [DATA_W-1:0] bp_y [MAX_BREAKPOINTS];
    int                       bp_count;

    t_answer pending_answers[$];
    int      mismatch_count;
    int      n_sent;
    bit      no_gaps;

    sorted_breakpoint_interpolator_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_opcode   (i_opcode),
        .i_x_value  (i_x_value),
        .i_y_value  (i_y_value),
        .o_strobe   (o_strobe),
        .o_status   (o_status),
        .o_y_result (o_y_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Insert into the sorted table (refused when full) or interpolate a query; updates table on insert
    function automatic t_answer predict_answer(input logic op,
                                               input logic signed [DATA_W-1:0] xv,
                                               input logic signed [DATA_W-1:0] yv);
        t_answer a;
        int      pos;
        int      k;
        longint  dy, dx, den, quot;
        a.y = '0;
        if (op == OP_INSERT) begin
            if (bp_count >= MAX_BREAKPOINTS) begin
                a.status = ST_REFUSED;
            end else begin
                pos = bp_count;
                // equal x lands after stored ones
                while (pos > 0 && bp_x[pos-1] > xv) begin
                    bp_x[pos] = bp_x[pos-1];
                    bp_y[pos] = bp_y[pos-1];
                    pos--;
                end
                bp_x[pos] = xv;
                bp_y[pos] = yv;
                bp_count++;
                a.status = ST_INSERTED;
            end
        end else begin
            a.status = ST_ANSWERED;
            if (bp_count == 0) begin
                a.y = '0;
            end else if (xv <= bp_x[0]) begin
                a.y = bp_y[0];
            end else if (xv >= bp_x[bp_count-1]) begin
                a.y = bp_y[bp_count-1];
            end else begin
                k = 0;
                while (k + 1 < bp_count && bp_x[k+1] < xv) k++;
                dy   = longint'(bp_y[k+1]) - longint'(bp_y[k]);
                dx   = longint'(xv) - longint'(bp_x[k]);
                den  = longint'(bp_x[k+1]) - longint'(bp_x[k]);
                quot = (dy * dx) / den;   // truncates toward zero
                a.y  = DATA_W'(longint'(bp_y[k]) + quot);
            end
        end
        return a;
    endfunction

    // One transaction: optional idle gap, then hold start until accepted
    task automatic send_cmd(input logic op,
                            input logic signed [DATA_W-1:0] xv,
                            input logic signed [DATA_W-1:0] yv);
        int gap;
        if (n_sent % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start     = 1'b1;
        i_opcode  = op;
        i_x_value = xv;
        i_y_value = yv;
        do @(posedge i_clk); while (busy);
        pending_answers.push_back(predict_answer(op, xv, yv));
        n_sent++;
    endtask

    task automatic wait_all_answered();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    // Query x: fully random, near a stored breakpoint, an end of the range, or the first or last x
    function automatic logic signed [DATA_W-1:0] pick_query_x();
        int sel;
        int idx;
        sel = $urandom_range(0, 99);
        if (sel < 45 || bp_count == 0) return DATA_W'($urandom);
        if (sel < 85) begin
            idx = $urandom_range(0, bp_count - 1);
            return bp_x[idx] + DATA_W'($urandom_range(0, 6)) - DATA_W'(3);
        end
        if (sel < 90) return 16'sh8000;
        if (sel < 95) return 16'sh7fff;
        return (sel < 98) ? bp_x[0] : bp_x[bp_count-1];
    endfunction

    // Result checker: each strobe against the oldest pending answer
    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && o_strobe) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result, status %0d y %0d", $time,
                         o_status, o_y_result);
                mismatch_count++;
            end else begin
                e = pending_answers.pop_front();
                if (o_status !== e.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, e.status, o_status);
                    mismatch_count++;
                end
                if (o_y_result !== e.y) begin
                    $display("%0t: y_result mismatch, expected %0d, actual %0d",
                             $time, e.y, o_y_result);
                    mismatch_count++;
                end
            end
        end
    end

    // Queries on the empty table
    task automatic test_empty_table();
        send_cmd(OP_QUERY, 16'sd0, 16'sd0);
        send_cmd(OP_QUERY, 16'sh8000, 16'sh7fff);
    endtask

    // One breakpoint: below, at and above it
    task automatic test_single_point();
        send_cmd(OP_INSERT, 16'sd256, 16'sd1000);
        send_cmd(OP_QUERY, 16'sd0, 16'shffff);
        send_cmd(OP_QUERY, 16'sd256, 16'sd0);
        send_cmd(OP_QUERY, 16'sh7fff, 16'sd0);
    endtask

    // Extreme breakpoints, wide spans and large products
    task automatic test_extremes();
        send_cmd(OP_INSERT, 16'sh8000, 16'sh8000);
        send_cmd(OP_INSERT, 16'sh7fff, 16'sh7fff);
        send_cmd(OP_QUERY, 16'sh8000, 16'sd0);
        send_cmd(OP_QUERY, 16'sh7fff, 16'sd0);
        send_cmd(OP_QUERY, 16'sd100, 16'sd0);
        send_cmd(OP_QUERY, -16'sd1, 16'sd0);
    endtask

    // Duplicate x values keep arrival order; negative quotient truncation
    task automatic test_equal_x();
        send_cmd(OP_INSERT, 16'sd256, -16'sd500);
        send_cmd(OP_INSERT, 16'sd256, 16'sd2000);
        send_cmd(OP_QUERY, 16'sd256, 16'sd0);
        send_cmd(OP_QUERY, 16'sd257, 16'sd0);
        send_cmd(OP_QUERY, 16'sd255, 16'sd0);
        send_cmd(OP_INSERT, 16'sd0, -16'sd1);
        send_cmd(OP_QUERY, -16'sd1, 16'sd0);
        send_cmd(OP_QUERY, 16'sd128, 16'sd0);
    endtask

    // Random mix of inserts and queries until the table is full
    task automatic test_random_fill();
        logic signed [DATA_W-1:0] xv;
        while (bp_count < MAX_BREAKPOINTS) begin
            if ($urandom_range(0, 5) == 0) begin
                xv = ($urandom_range(0, 3) == 0) ? bp_x[$urandom_range(0, bp_count - 1)]
                                                 : DATA_W'($urandom);
                send_cmd(OP_INSERT, xv, DATA_W'($urandom));
            end else begin
                send_cmd(OP_QUERY, pick_query_x(), DATA_W'($urandom));
            end
        end
    endtask

    // Full table: refused inserts, deepest walk, after a full drain
    task automatic test_full_table();
        wait_all_answered();
        send_cmd(OP_INSERT, 16'sh8000, 16'sh7fff);
        send_cmd(OP_INSERT, 16'sh7fff, 16'sh8000);
        send_cmd(OP_INSERT, DATA_W'($urandom), DATA_W'($urandom));
        send_cmd(OP_QUERY, bp_x[MAX_BREAKPOINTS-1] - 16'sd1, 16'sd0);
        send_cmd(OP_QUERY, bp_x[MAX_BREAKPOINTS-2] + 16'sd1, 16'sd0);
        send_cmd(OP_QUERY, bp_x[1] - 16'sd1, 16'sd0);
    endtask

    // Long random run of queries with occasional refused inserts
    task automatic test_random_queries();
        repeat (860) begin
            if ($urandom_range(0, 9) == 0)
                send_cmd(OP_INSERT, DATA_W'($urandom), DATA_W'($urandom));
            else
                send_cmd(OP_QUERY, pick_query_x(), DATA_W'($urandom));
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_opcode       = OP_INSERT;
        i_x_value      = '0;
        i_y_value      = '0;
        bp_count       = 0;
        mismatch_count = 0;
        n_sent         = 0;
        no_gaps        = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_single_point();
        test_extremes();
        test_equal_x();
        test_random_fill();
        test_full_table();
        test_random_queries();

        wait_all_answered();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("sorted_breakpoint_interpolator_core_test: done, clean");
        else
            $display("sorted_breakpoint_interpolator_core_test: done, errors");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("sorted_breakpoint_interpolator_core_test: done, errors");
        $finish;
    end

endmodule

// ===== sorted_breakpoint_interpolator_core.f =====
sv/sbi_pkg.sv
sv/sbi_ram.sv
sv/sbi_datapath.sv
sv/sbi_ctrl.sv
sv/sorted_breakpoint_interpolator_core.sv
sv/sbi_checker.sv
tb/sorted_breakpoint_interpolator_core_test.sv
